// ===== design/atsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atsp_pkg
// Shared types and constants for the tilt angle / servo level pipeline.
// ----------------------------------------------------------------------------
package atsp_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 8;
	localparam int CORDIC_STAGES_DEF   = 16;

	localparam int ACC_FRAC   = 24;
	localparam int TABLE_LEN  = 24;
	localparam int ACC_W      = 32;
	localparam int CORD_W     = 36;
	localparam int ROOT_W     = 32;
	localparam int REM_W      = 35;
	localparam int SQ_STAGES  = ROOT_W / 2;
	localparam int DEG_90     = 90;

	// floor(v / 90) = (v * RECIP_MULT) >> RECIP_SHIFT for v below 2^23
	localparam int RECIP_SHIFT = 30;
	localparam logic [23:0] RECIP_MULT = 24'd11930465;
	localparam int QUOT_IN_W   = 23;

	localparam int CFG_ADDR_W = 8;
	localparam logic [15:0] PULSE_BASE_RST = 16'd500;
	localparam logic [15:0] PULSE_SPAN_RST = 16'd110;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_PULSE_BASE = 8'd0,
		REG_PULSE_SPAN = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [31:0]       bits;
	} sqrt_st_t;

	// One digit of the integer square root: bring in two radicand bits.
	function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
		sqrt_st_t         o;
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;
		cur   = {s.rem[REM_W-3:0], s.bits[31:30]};
		trial = {1'b0, s.root, 2'b01};
		o.bits = {s.bits[29:0], 2'b00};
		if (cur >= trial) begin
			o.rem  = cur - trial;
			o.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = cur;
			o.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// atan(2^-i) in degrees with ACC_FRAC fraction bits
	function automatic logic signed [ACC_W-1:0] atan_deg(input int i);
		logic signed [ACC_W-1:0] v;
		unique case (i)
			0:  v = 32'sd754974720;
			1:  v = 32'sd445687602;
			2:  v = 32'sd235489088;
			3:  v = 32'sd119537938;
			4:  v = 32'sd60000934;
			5:  v = 32'sd30029717;
			6:  v = 32'sd15018523;
			7:  v = 32'sd7509720;
			8:  v = 32'sd3754917;
			9:  v = 32'sd1877466;
			10: v = 32'sd938734;
			11: v = 32'sd469367;
			12: v = 32'sd234684;
			13: v = 32'sd117342;
			14: v = 32'sd58671;
			15: v = 32'sd29335;
			16: v = 32'sd14668;
			17: v = 32'sd7334;
			18: v = 32'sd3667;
			19: v = 32'sd1833;
			20: v = 32'sd917;
			21: v = 32'sd458;
			22: v = 32'sd229;
			23: v = 32'sd115;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== design/atsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atsp interfaces
// Sample, result and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface atsp_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	modport source (output valid, accel_x, accel_y, accel_z, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atsp_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] tilt_degrees;
	logic        [15:0] servo_level;
	modport source (output valid, tilt_degrees, servo_level, input ready);
	modport sink   (input valid, tilt_degrees, servo_level, output ready);
endinterface

interface atsp_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  addr;
	logic [15:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ===== design/accel_tilt_to_servo_pulse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_to_servo_pulse
// Tilt angle atan2(x, sqrt(y^2+z^2)) in degrees and servo target level.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one accelerometer request (accel_x/y/z, signed counts).
//   result : tilt_degrees (signed, ANGLE_FRAC_BITS fraction bits) and
//            servo_level = pulse_base + |tilt| * pulse_span / 90, saturated.
//   cfg    : register writes, addr 0 = pulse_base, 1 = pulse_span; other
//            addresses are dropped. Always ready.
// From request to result: squaring and the sum of squares, 16 square root
// stages of two root bits each, one CORDIC rotation per stage, then rounding,
// the span multiply, the divide by 90 and the output register. One request is
// taken every cycle while the pipeline is not held by a stalled receiver.
// Every stage has its own valid bit and advances when the stage after it is
// empty or moving, so bubbles collapse while the receiver stalls and requests
// are still taken until the pipeline is full.
// Reset clears all valid bits and loads pulse_base = 500, pulse_span = 110.
// ----------------------------------------------------------------------------
module accel_tilt_to_servo_pulse #(
	parameter int ANGLE_FRAC_BITS = atsp_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = atsp_pkg::CORDIC_STAGES_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	atsp_sample_if.sink   sample,
	atsp_result_if.source result,
	atsp_cfg_if.sink      cfg
);
	import atsp_pkg::*;

	localparam int AW       = ANGLE_FRAC_BITS + 8;
	localparam int MW       = AW - 1;
	localparam int PW       = MW + 16;
	localparam int SH       = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam logic [ACC_W:0] HALF = (ACC_W+1)'(1) << (SH - 1);
	localparam logic [MW-1:0]  LIM  = MW'(DEG_90) << ANGLE_FRAC_BITS;
	localparam logic signed [ACC_W-1:0] ACC_90 = ACC_W'(DEG_90) << ACC_FRAC;

	localparam int I_SUM = 1;
	localparam int I_SQ  = 2;
	localparam int I_CR  = I_SQ + SQ_STAGES;
	localparam int I_RND = I_CR + CORDIC_STAGES;
	localparam int I_MUL = I_RND + 1;
	localparam int I_DIV = I_RND + 2;
	localparam int I_OUT = I_RND + 3;
	localparam int L     = I_RND + 4;

	logic [L-1:0] vld_q;
	logic [L-1:0] en;

	// advance a stage when it is empty or the next one advances
	always_comb begin
		en[L-1] = !vld_q[L-1] || result.ready;
		for (int i = L - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= sample.valid;
			end
			for (int i = 1; i < L; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign sample.ready = en[0];

	// registers
	logic [15:0] base_q;
	logic [15:0] span_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= PULSE_BASE_RST;
			span_q <= PULSE_SPAN_RST;
		end else if (cfg.valid) begin
			if (cfg.addr == REG_PULSE_BASE) begin
				base_q <= cfg.data;
			end
			if (cfg.addr == REG_PULSE_SPAN) begin
				span_q <= cfg.data;
			end
		end
	end

	// squares
	logic signed [15:0] x_s1;
	logic               zx_s1;
	logic [31:0]        ysq_s1;
	logic [31:0]        zsq_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1   <= sample.accel_x;
			zx_s1  <= (sample.accel_x == '0);
			ysq_s1 <= 32'(sample.accel_y * sample.accel_y);
			zsq_s1 <= 32'(sample.accel_z * sample.accel_z);
		end
	end

	logic signed [15:0] x_s2;
	logic               zx_s2;
	logic               zss_s2;
	logic [31:0]        ss_s2;

	always_ff @(posedge clk) begin
		if (en[I_SUM]) begin
			x_s2   <= x_s1;
			zx_s2  <= zx_s1;
			zss_s2 <= (ysq_s1 == '0) && (zsq_s1 == '0);
			ss_s2  <= ysq_s1 + zsq_s1;
		end
	end

	// square root of ss * 2^32, two root bits per stage
	sqrt_st_t           sq_s3  [SQ_STAGES];
	logic signed [15:0] x_s3   [SQ_STAGES];
	logic               zx_s3  [SQ_STAGES];
	logic               zss_s3 [SQ_STAGES];

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
		sqrt_st_t           st_in;
		logic signed [15:0] x_in;
		logic               zx_in;
		logic               zss_in;

		if (k == 0) begin : g_first
			always_comb begin
				st_in.rem  = '0;
				st_in.root = '0;
				st_in.bits = ss_s2;
				x_in       = x_s2;
				zx_in      = zx_s2;
				zss_in     = zss_s2;
			end
		end else begin : g_next
			always_comb begin
				st_in  = sq_s3[k-1];
				x_in   = x_s3[k-1];
				zx_in  = zx_s3[k-1];
				zss_in = zss_s3[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[I_SQ+k]) begin
				sq_s3[k]  <= sqrt_step(sqrt_step(st_in));
				x_s3[k]   <= x_in;
				zx_s3[k]  <= zx_in;
				zss_s3[k] <= zss_in;
			end
		end
	end

	// CORDIC vectoring, one rotation per stage
	logic signed [CORD_W-1:0] cx_s4  [CORDIC_STAGES];
	logic signed [CORD_W-1:0] cy_s4  [CORDIC_STAGES];
	logic signed [ACC_W-1:0]  acc_s4 [CORDIC_STAGES];
	logic signed [15:0]       x_s4   [CORDIC_STAGES];
	logic                     zx_s4  [CORDIC_STAGES];
	logic                     zss_s4 [CORDIC_STAGES];

	for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cordic
		logic signed [CORD_W-1:0] cx_in;
		logic signed [CORD_W-1:0] cy_in;
		logic signed [ACC_W-1:0]  acc_in;
		logic signed [15:0]       x_in;
		logic                     zx_in;
		logic                     zss_in;
		logic signed [CORD_W-1:0] dx;
		logic signed [CORD_W-1:0] dy;

		if (j == 0) begin : g_first
			always_comb begin
				cx_in  = signed'({{(CORD_W-ROOT_W){1'b0}}, sq_s3[SQ_STAGES-1].root});
				cy_in  = CORD_W'(x_s3[SQ_STAGES-1]) <<< 16;
				acc_in = '0;
				x_in   = x_s3[SQ_STAGES-1];
				zx_in  = zx_s3[SQ_STAGES-1];
				zss_in = zss_s3[SQ_STAGES-1];
			end
		end else begin : g_next
			always_comb begin
				cx_in  = cx_s4[j-1];
				cy_in  = cy_s4[j-1];
				acc_in = acc_s4[j-1];
				x_in   = x_s4[j-1];
				zx_in  = zx_s4[j-1];
				zss_in = zss_s4[j-1];
			end
		end

		assign dx = cy_in >>> j;
		assign dy = cx_in >>> j;

		always_ff @(posedge clk) begin
			if (en[I_CR+j]) begin
				if (!cy_in[CORD_W-1]) begin
					cx_s4[j]  <= cx_in + dx;
					cy_s4[j]  <= cy_in - dy;
					acc_s4[j] <= acc_in + atan_deg(j);
				end else begin
					cx_s4[j]  <= cx_in - dx;
					cy_s4[j]  <= cy_in + dy;
					acc_s4[j] <= acc_in - atan_deg(j);
				end
				x_s4[j]   <= x_in;
				zx_s4[j]  <= zx_in;
				zss_s4[j] <= zss_in;
			end
		end
	end

	// round halves away from zero, clamp to 90 degrees
	logic signed [ACC_W-1:0] acc_f;
	logic [ACC_W:0]          acc_abs;
	logic [ACC_W:0]          rnd;
	logic [MW-1:0]           mag_c;
	logic signed [AW-1:0]    ang_s5;
	logic [MW-1:0]           mag_s5;

	always_comb begin
		priority if (zx_s4[CORDIC_STAGES-1]) begin
			acc_f = '0;
		end else if (zss_s4[CORDIC_STAGES-1]) begin
			acc_f = x_s4[CORDIC_STAGES-1][15] ? -ACC_90 : ACC_90;
		end else begin
			acc_f = acc_s4[CORDIC_STAGES-1];
		end
		acc_abs = acc_f[ACC_W-1] ? (ACC_W+1)'(-33'(acc_f)) : (ACC_W+1)'(acc_f);
		rnd     = (acc_abs + HALF) >> SH;
		mag_c   = (rnd > (ACC_W+1)'(LIM)) ? LIM : MW'(rnd);
	end

	always_ff @(posedge clk) begin
		if (en[I_RND]) begin
			mag_s5 <= mag_c;
			ang_s5 <= acc_f[ACC_W-1] ? -signed'({1'b0, mag_c}) : signed'({1'b0, mag_c});
		end
	end

	// level: mag * span, then divide by 90 << ANGLE_FRAC_BITS
	logic [PW-1:0]        prod_s6;
	logic signed [AW-1:0] ang_s6;

	always_ff @(posedge clk) begin
		if (en[I_MUL]) begin
			prod_s6 <= PW'(mag_s5) * PW'(span_q);
			ang_s6  <= ang_s5;
		end
	end

	logic [QUOT_IN_W-1:0]    quot_in;
	logic [QUOT_IN_W+23:0]   recip;
	logic [15:0]             quot_s7;
	logic signed [AW-1:0]    ang_s7;

	assign quot_in = QUOT_IN_W'(prod_s6 >> ANGLE_FRAC_BITS);
	assign recip   = (QUOT_IN_W+24)'(quot_in) * (QUOT_IN_W+24)'(RECIP_MULT);

	always_ff @(posedge clk) begin
		if (en[I_DIV]) begin
			quot_s7 <= recip[RECIP_SHIFT+15:RECIP_SHIFT];
			ang_s7  <= ang_s6;
		end
	end

	logic [16:0]        lvl_sum;
	logic signed [15:0] tilt_s8;
	logic [15:0]        level_s8;

	assign lvl_sum = {1'b0, base_q} + {1'b0, quot_s7};

	// hold result while the receiver stalls
	always_ff @(posedge clk) begin
		if (en[I_OUT]) begin
			tilt_s8  <= 16'(ang_s7);
			level_s8 <= lvl_sum[16] ? 16'hFFFF : lvl_sum[15:0];
		end
	end

	assign result.valid        = vld_q[I_OUT];
	assign result.tilt_degrees = tilt_s8;
	assign result.servo_level  = level_s8;

endmodule
`default_nettype wire
